// ===== rtl/slba_pkg.sv =====
// ----------------------------------------------------------------------------
// slba_pkg
// Shared types, codes and helpers of the slot bitmap range allocator.
// ----------------------------------------------------------------------------
package slba_pkg;

	localparam int NUM_BLOCKS      = 256;
	localparam int SLOTS_PER_BLOCK = 64;
	localparam int BLK_W           = $clog2(NUM_BLOCKS);
	localparam int SLOT_W          = $clog2(SLOTS_PER_BLOCK);
	localparam int NB_W            = BLK_W + 1;
	localparam int IDX_W           = 14;
	localparam int CNT_W           = 15;

	typedef logic [SLOTS_PER_BLOCK-1:0] word_t;

	typedef struct packed {
		logic  mapped;
		word_t bits;
	} entry_t;

	// per-block scan figures
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] pos;
		logic [SLOT_W:0]   tz;
		logic [SLOT_W:0]   lz;
	} blk_info_t;

	localparam logic [1:0] ACT_SEARCH = 2'd0;
	localparam logic [1:0] ACT_FIXED  = 2'd1;
	localparam logic [1:0] ACT_FREE   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FAIL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	localparam logic [1:0] CFG_AVAIL = 2'd0;
	localparam logic [1:0] CFG_KEEP  = 2'd1;

	// slots of block blk that fall inside [first_slot, last_slot]
	function automatic word_t range_mask(input logic [BLK_W-1:0] blk,
		input logic [IDX_W-1:0] first_slot, input logic [IDX_W-1:0] last_slot);
		logic [SLOT_W-1:0] lo;
		logic [SLOT_W-1:0] hi;
		word_t ones;
		ones = '1;
		lo = (blk == first_slot[IDX_W-1:SLOT_W]) ? first_slot[SLOT_W-1:0] : '0;
		hi = (blk == last_slot[IDX_W-1:SLOT_W]) ? last_slot[SLOT_W-1:0] : '1;
		return (ones << lo) & (ones >> (~hi));
	endfunction

endpackage

// ===== rtl/slba_mem.sv =====
// ----------------------------------------------------------------------------
// slba_mem
// Block bitmap store: one entry per block, registered read, per-entry valid.
// ----------------------------------------------------------------------------
module slba_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [slba_pkg::BLK_W-1:0]  rd_addr,
	output slba_pkg::entry_t            rd_data,
	input  logic                        wr_en,
	input  logic [slba_pkg::BLK_W-1:0]  wr_addr,
	input  slba_pkg::entry_t            wr_data
);

	slba_pkg::entry_t mem_q [slba_pkg::NUM_BLOCKS];
	slba_pkg::entry_t rd_q;
	logic [slba_pkg::NUM_BLOCKS-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// never-written entries read as empty and unmapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/slba_eval.sv =====
// ----------------------------------------------------------------------------
// slba_eval
// Per-block figures: first free window of a given length, free prefix/suffix.
// ----------------------------------------------------------------------------
module slba_eval (
	input  slba_pkg::word_t              used,
	input  logic [slba_pkg::SLOT_W:0]    need,
	output slba_pkg::blk_info_t          info
);

	always_comb begin
		slba_pkg::word_t lvl [slba_pkg::SLOT_W+1];
		slba_pkg::word_t win;
		int unsigned sh;
		// lvl[k] bit i: 2**k free slots start at i
		lvl[0] = ~used;
		for (int k = 1; k <= slba_pkg::SLOT_W; k++) begin
			lvl[k] = lvl[k-1] & (lvl[k-1] >> (1 << (k - 1)));
		end
		win = '1;
		sh  = 0;
		for (int k = 0; k <= slba_pkg::SLOT_W; k++) begin
			if (need[k]) begin
				win = win & (lvl[k] >> sh);
				sh  = sh + (1 << k);
			end
		end
		info.found = |win;
		info.pos   = '0;
		for (int i = slba_pkg::SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
			if (win[i]) begin
				info.pos = slba_pkg::SLOT_W'(i);
			end
		end
		info.tz = (slba_pkg::SLOT_W+1)'(slba_pkg::SLOTS_PER_BLOCK);
		for (int i = slba_pkg::SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
			if (used[i]) begin
				info.tz = (slba_pkg::SLOT_W+1)'(i);
			end
		end
		info.lz = (slba_pkg::SLOT_W+1)'(slba_pkg::SLOTS_PER_BLOCK);
		for (int i = 0; i < slba_pkg::SLOTS_PER_BLOCK; i++) begin
			if (used[i]) begin
				info.lz = (slba_pkg::SLOT_W+1)'(slba_pkg::SLOTS_PER_BLOCK - 1 - i);
			end
		end
	end

endmodule

// ===== rtl/slot_bitmap_range_allocator.sv =====
// Sequence: a check state, then per request kind:
//   fixed alloc: a range check scan of the B blocks touched, then a read and
//   a write-back of each; free: those writes alone; search: up to four scan
//   passes over the n blocks in use, then those writes. Result strobe is registered.
// Throughput: one request at a time; in a scan the memory gives one block per cycle.
// Reset: async, all blocks read empty and unmapped at once (per-block valid flops).
// ----------------------------------------------------------------------------
// slot_bitmap_range_allocator
// First-fit contiguous slot allocator over per-block bitmaps.
// ----------------------------------------------------------------------------
module slot_bitmap_range_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [slba_pkg::IDX_W-1:0]    slot_index,
	input  logic [slba_pkg::CNT_W-1:0]    slot_count,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [slba_pkg::IDX_W-1:0]    slot_start,
	output logic [slba_pkg::NB_W-1:0]     mapped_blocks,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [slba_pkg::NB_W-1:0]     cfg_data
);

	localparam int BW = slba_pkg::BLK_W;
	localparam int SW = slba_pkg::SLOT_W;
	localparam int NW = slba_pkg::NB_W;
	localparam int IW = slba_pkg::IDX_W;
	localparam int CW = slba_pkg::CNT_W;
	localparam logic [1:0] LAST_PASS = 2'd3;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_PASS, S_SCAN, S_WR_RD, S_WR_WB} state_t;
	typedef enum logic [2:0] {K_FIX, K_WIN, K_PAIR, K_ALIGN, K_MID} kind_t;

	state_t state_q;
	kind_t  kind_q;
	kind_t  pass_kind;
	logic [1:0] pass_q;
	logic iss_q, vld_s1, last_s1, mact_q, prev_vld_q;
	logic done_q;
	logic [1:0] status_q;
	logic [IW-1:0] start_slot_q;
	logic [NW-1:0] mb_q, count_q, ssb_q, avail_q;
	logic keep_q;

	logic [1:0] act_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] a_q;
	logic [BW-1:0] j_q, end_q, j_s1;
	logic [NW-1:0] hx_q, run_q;
	logic [SW:0] prev_suf_q;
	logic [IW-1:0] mstart_q;
	logic [CW-1:0] mlen_q;

	slba_pkg::entry_t rd, wr;
	slba_pkg::blk_info_t info;
	logic rd_en, wr_en, issue, ev, hit, fix_bad, scan_stop;
	logic [IW-1:0] hit_at, e_slot;
	logic [NW-1:0] nb, blen, cnt_upd, ssb_upd;
	logic [CW-1:0] total, mlen_next;
	logic [BW-1:0] st, nb_m1, pass_lo, pass_end;
	logic [NW-1:0] pass_hx;
	logic pass_empty, short_req, over, wb_last, is_free, mid_new, mid_keep;
	logic [SW:0] need7, lastneed, want;
	logic [NW:0] al_blk;
	logic [CW-1:0] sum_end;
	slba_pkg::word_t wmask, nbits;

	assign nb     = (avail_q > NW'(slba_pkg::NUM_BLOCKS)) ? NW'(slba_pkg::NUM_BLOCKS) : avail_q;
	assign total  = CW'({nb, {SW{1'b0}}});
	assign st     = (ssb_q >= nb) ? '0 : ssb_q[BW-1:0];
	assign nb_m1  = BW'(nb - NW'(1));
	assign short_req = cnt_q <= CW'(slba_pkg::SLOTS_PER_BLOCK);
	assign need7  = cnt_q[SW:0];
	assign blen   = NW'(cnt_q[CW-1:SW]) + NW'(|cnt_q[SW-1:0]);
	assign lastneed = (|cnt_q[SW-1:0]) ? {1'b0, cnt_q[SW-1:0]} : (SW+1)'(slba_pkg::SLOTS_PER_BLOCK);
	assign over   = ({2'b00, a_q} + {1'b0, cnt_q}) > {1'b0, total};
	assign e_slot = a_q + cnt_q[IW-1:0] - IW'(1);
	assign sum_end = CW'({1'b0, a_q}) + cnt_q;
	assign is_free = act_q == slba_pkg::ACT_FREE;

	slba_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (j_q),
		.rd_data (rd),
		.wr_en   (wr_en),
		.wr_addr (j_q),
		.wr_data (wr)
	);

	slba_eval u_eval (
		.used (rd.bits),
		.need (need7),
		.info (info)
	);

	// scan pass setup: block range and candidate limit
	always_comb begin
		pass_lo    = '0;
		pass_end   = nb_m1;
		pass_hx    = nb;
		pass_empty = (nb == '0);
		pass_kind  = short_req ? K_WIN : K_ALIGN;
		case (pass_q)
			2'd0: begin
				pass_lo = st;
			end
			2'd1: begin
				pass_empty = (st == '0);
				pass_hx    = {1'b0, st};
				if (short_req) begin
					pass_end = st - BW'(1);
				end
			end
			2'd2: begin
				pass_lo   = st;
				pass_kind = short_req ? K_PAIR : K_MID;
			end
			default: begin
				pass_empty = (st == '0);
				pass_hx    = {1'b0, st};
				pass_kind  = short_req ? K_PAIR : K_MID;
				if (short_req) begin
					pass_end = st;
				end
			end
		endcase
	end

	// evaluate the block just read
	always_comb begin
		ev        = (state_q == S_SCAN) && vld_s1;
		hit       = 1'b0;
		hit_at    = '0;
		fix_bad   = 1'b0;
		want      = need7 - prev_suf_q;
		mlen_next = mlen_q + CW'(info.tz);
		al_blk    = {2'b00, j_s1} + (NW+1)'(1) - {1'b0, blen};
		mid_keep  = mact_q && info.tz[SW];
		mid_new   = !mid_keep && ({1'b0, j_s1} < hx_q) && (info.lz != '0);
		case (kind_q)
			K_FIX: begin
				fix_bad = |(rd.bits & slba_pkg::range_mask(j_s1, a_q, e_slot));
			end
			K_WIN: begin
				hit    = info.found;
				hit_at = {j_s1, info.pos};
			end
			K_PAIR: begin
				hit    = prev_vld_q && (prev_suf_q != '0) && (prev_suf_q < need7)
					&& (info.tz >= want);
				hit_at = {j_s1, {SW{1'b0}}} - IW'(prev_suf_q);
			end
			K_ALIGN: begin
				hit    = (run_q >= blen - NW'(1)) && (info.tz >= lastneed)
					&& (({2'b00, j_s1} + (NW+1)'(1)) < ({1'b0, hx_q} + {1'b0, blen}));
				hit_at = {al_blk[BW-1:0], {SW{1'b0}}};
			end
			K_MID: begin
				hit    = mact_q && (mlen_next >= cnt_q);
				hit_at = mstart_q;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		hit       = hit && ev;
		fix_bad   = fix_bad && ev;
		scan_stop = ev && (hit || fix_bad || last_s1);
		issue     = (state_q == S_SCAN) && iss_q && !scan_stop;
		rd_en     = issue || (state_q == S_WR_RD);
	end

	// read-modify-write of one block
	always_comb begin
		wmask   = slba_pkg::range_mask(j_q, a_q, e_slot);
		wr_en   = state_q == S_WR_WB;
		wb_last = j_q == e_slot[IW-1:SW];
		cnt_upd = count_q;
		nbits   = rd.bits & ~wmask;
		if (is_free) begin
			wr.bits   = nbits;
			wr.mapped = rd.mapped;
			if ((nbits == '0) && rd.mapped && !keep_q) begin
				wr.mapped = 1'b0;
				if (count_q != '0) begin
					cnt_upd = count_q - NW'(1);
				end
			end
		end else begin
			wr.bits   = (rd.mapped ? rd.bits : '0) | wmask;
			wr.mapped = 1'b1;
			if (!rd.mapped) begin
				cnt_upd = count_q + NW'(1);
			end
		end
		ssb_upd = ssb_q;
		if (is_free) begin
			if (ssb_q > {1'b0, a_q[IW-1:SW]}) begin
				ssb_upd = {1'b0, a_q[IW-1:SW]};
			end
		end else if (act_q == slba_pkg::ACT_SEARCH) begin
			if (sum_end[CW-1:SW] > ssb_q) begin
				ssb_upd = sum_end[CW-1:SW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= K_FIX;
			pass_q       <= '0;
			iss_q        <= 1'b0;
			vld_s1       <= 1'b0;
			mact_q       <= 1'b0;
			prev_vld_q   <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= slba_pkg::ST_OK;
			start_slot_q <= '0;
			mb_q         <= '0;
			count_q      <= '0;
			ssb_q        <= '0;
			avail_q      <= NW'(slba_pkg::NUM_BLOCKS);
			keep_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			if (cfg_valid) begin
				case (cfg_index)
					slba_pkg::CFG_AVAIL: avail_q <= cfg_data;
					slba_pkg::CFG_KEEP:  keep_q  <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cnt_q == '0) begin
						done_q <= 1'b1; status_q <= slba_pkg::ST_ZERO;
						start_slot_q <= '0; mb_q <= count_q; state_q <= S_IDLE;
					end else begin
						case (act_q)
							slba_pkg::ACT_SEARCH: begin
								pass_q  <= '0;
								state_q <= S_PASS;
							end
							slba_pkg::ACT_FIXED, slba_pkg::ACT_FREE: begin
								if (over) begin
									done_q <= 1'b1; status_q <= slba_pkg::ST_RANGE;
									start_slot_q <= '0; mb_q <= count_q; state_q <= S_IDLE;
								end else if (is_free) begin
									state_q <= S_WR_RD;
								end else begin
									kind_q  <= K_FIX;
									iss_q   <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							default: begin
								done_q <= 1'b1; status_q <= slba_pkg::ST_FAIL;
								start_slot_q <= '0; mb_q <= count_q; state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PASS: begin
					if (pass_empty) begin
						if (pass_q == LAST_PASS) begin
							done_q <= 1'b1; status_q <= slba_pkg::ST_FAIL;
							start_slot_q <= '0; mb_q <= count_q; state_q <= S_IDLE;
						end else begin
							pass_q <= pass_q + 2'd1;
						end
					end else begin
						kind_q     <= pass_kind;
						iss_q      <= 1'b1;
						prev_vld_q <= 1'b0;
						mact_q     <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue && (j_q == end_q)) begin
						iss_q <= 1'b0;
					end
					if (ev) begin
						prev_vld_q <= 1'b1;
						mact_q     <= mid_keep || mid_new;
					end
					if (fix_bad) begin
						iss_q  <= 1'b0;
						done_q <= 1'b1; status_q <= slba_pkg::ST_FAIL;
						start_slot_q <= '0; mb_q <= count_q; state_q <= S_IDLE;
					end else if (hit) begin
						iss_q   <= 1'b0;
						state_q <= S_WR_RD;
					end else if (ev && last_s1) begin
						if (kind_q == K_FIX) begin
							state_q <= S_WR_RD;
						end else if (pass_q == LAST_PASS) begin
							done_q <= 1'b1; status_q <= slba_pkg::ST_FAIL;
							start_slot_q <= '0; mb_q <= count_q; state_q <= S_IDLE;
						end else begin
							pass_q  <= pass_q + 2'd1;
							state_q <= S_PASS;
						end
					end
				end
				S_WR_RD: begin
					state_q <= S_WR_WB;
				end
				S_WR_WB: begin
					count_q <= cnt_upd;
					if (wb_last) begin
						ssb_q   <= ssb_upd;
						done_q  <= 1'b1; status_q <= slba_pkg::ST_OK;
						start_slot_q <= a_q; mb_q <= cnt_upd; state_q <= S_IDLE;
					end else begin
						state_q <= S_WR_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					act_q <= action;
					a_q   <= slot_index;
					cnt_q <= slot_count;
				end
			end
			S_CHECK: begin
				j_q   <= a_q[IW-1:SW];
				end_q <= e_slot[IW-1:SW];
			end
			S_PASS: begin
				j_q   <= pass_lo;
				end_q <= pass_end;
				hx_q  <= pass_hx;
				run_q <= '0;
			end
			S_SCAN: begin
				if (issue) begin
					j_q     <= j_q + BW'(1);
					j_s1    <= j_q;
					last_s1 <= j_q == end_q;
				end
				if (ev) begin
					run_q      <= info.tz[SW] ? run_q + NW'(1) : '0;
					prev_suf_q <= info.lz;
					if (mid_new) begin
						mstart_q <= {j_s1, {SW{1'b0}}} + IW'(slba_pkg::SLOTS_PER_BLOCK) - IW'(info.lz);
						mlen_q   <= CW'(info.lz);
					end else if (mid_keep) begin
						mlen_q <= mlen_next;
					end
				end
				if (hit) begin
					a_q <= hit_at;
					j_q <= hit_at[IW-1:SW];
				end else if (ev && last_s1 && (kind_q == K_FIX)) begin
					j_q <= a_q[IW-1:SW];
				end
			end
			S_WR_WB: begin
				j_q <= j_q + BW'(1);
			end
			default: ;
		endcase
	end

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign status        = status_q;
	assign slot_start    = start_slot_q;
	assign mapped_blocks = mb_q;
	assign cfg_ready     = 1'b1;

endmodule

// ===== rtl/slba_chk.sv =====
// ----------------------------------------------------------------------------
// slba_chk
// Port-level checks of the allocator's request/result sequencing.
// ----------------------------------------------------------------------------
module slba_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [slba_pkg::IDX_W-1:0]  slot_start
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on two cycles in a row");

	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != slba_pkg::ST_OK) |-> slot_start == '0)
		else $error("failed request reports a nonzero start slot");

endmodule

bind slot_bitmap_range_allocator slba_chk u_slba_chk (.*);

// ===== dv/slot_bitmap_range_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_bitmap_range_allocator_test
// Drives search, fixed and free requests with register settings changed
// between phases, predicts each result and checks status, start slot and
// mapped block count of every result strobe.
// ----------------------------------------------------------------------------
module slot_bitmap_range_allocator_test;
	import slba_pkg::*;

	localparam logic [1:0] ACT_UNDEF = 2'd3;
	localparam int WDOG_LIMIT = 40000;
	localparam int RAND_ITEMS = 2000;

	typedef struct {
		logic [1:0]       st;
		logic [IDX_W-1:0] first;
		logic [NB_W-1:0]  nmapped;
	} alloc_result_t;

	typedef struct {
		int first;
		int cnt;
	} run_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          action;
	logic [IDX_W-1:0]    slot_index;
	logic [CNT_W-1:0]    slot_count;
	logic                done;
	logic [1:0]          status;
	logic [IDX_W-1:0]    slot_start;
	logic [NB_W-1:0]     mapped_blocks;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [NB_W-1:0]     cfg_data;

	slot_bitmap_range_allocator dut (.*);

	// predicted allocator state
	logic [63:0] heap_bits [NUM_BLOCKS];
	bit          heap_mapped [NUM_BLOCKS];
	int          scan_from;
	int          mapped_total;
	int          cfg_avail;
	bit          cfg_keep;

	alloc_result_t result_q[$];
	run_t          live_runs[$];
	int            errors;
	int            idle_cycles;
	int            burst_left;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] ones_mask(int n);
		if (n >= 64) return '1;
		if (n <= 0) return '0;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int blocks_used();
		return cfg_avail > NUM_BLOCKS ? NUM_BLOCKS : cfg_avail;
	endfunction

	function automatic bit blk_ok(int b);
		return b >= 0 && b < blocks_used();
	endfunction

	function automatic bit blk_full(int b);
		if (!blk_ok(b)) return 1;
		if (!heap_mapped[b]) return 0;
		return heap_bits[b] == ones_mask(SLOTS_PER_BLOCK);
	endfunction

	function automatic bit blk_empty(int b);
		if (!blk_ok(b)) return 0;
		if (!heap_mapped[b]) return 1;
		return heap_bits[b] == 0;
	endfunction

	function automatic int tail_free(int b);
		int n;
		n = 0;
		if (!blk_ok(b)) return 0;
		if (!heap_mapped[b]) return SLOTS_PER_BLOCK;
		for (int i = SLOTS_PER_BLOCK - 1; i >= 0 && !heap_bits[b][i]; i--) n++;
		return n;
	endfunction

	function automatic bit head_free(int b, int want);
		if (want <= 0) return 1;
		if (!blk_ok(b)) return 0;
		if (!heap_mapped[b]) return want <= SLOTS_PER_BLOCK;
		if (want > SLOTS_PER_BLOCK) return 0;
		return (heap_bits[b] & ones_mask(want)) == 0;
	endfunction

	function automatic int first_gap(logic [63:0] used, int need);
		logic [63:0] m;
		if (need <= 0 || need > SLOTS_PER_BLOCK) return -1;
		if (need == SLOTS_PER_BLOCK) return used == 0 ? 0 : -1;
		m = ones_mask(need);
		for (int b = 0; b <= SLOTS_PER_BLOCK - need; b++)
			if ((used & (m << b)) == 0) return b;
		return -1;
	endfunction

	function automatic bit span_free(int first, int need);
		int slot, left, b, bitpos, take;
		slot = first;
		left = need;
		if (first < 0 || need <= 0 || first + need > blocks_used() * SLOTS_PER_BLOCK) return 0;
		while (left > 0) begin
			b = slot / SLOTS_PER_BLOCK;
			bitpos = slot % SLOTS_PER_BLOCK;
			take = SLOTS_PER_BLOCK - bitpos;
			if (!blk_ok(b)) return 0;
			if (take > left) take = left;
			if (heap_mapped[b] && (heap_bits[b] & (ones_mask(take) << bitpos)) != 0) return 0;
			slot += take;
			left -= take;
		end
		return 1;
	endfunction

	function automatic int fit_in_block(int b, int need);
		int pos;
		if (need <= 0 || need > SLOTS_PER_BLOCK || !blk_ok(b)) return -1;
		if (!heap_mapped[b]) return b * SLOTS_PER_BLOCK;
		if (heap_bits[b] == ones_mask(SLOTS_PER_BLOCK)) return -1;
		pos = first_gap(heap_bits[b], need);
		return pos < 0 ? -1 : b * SLOTS_PER_BLOCK + pos;
	endfunction

	function automatic int fit_aligned(int lo, int hi, int need);
		int full, rem, last;
		bit ok;
		full = need / SLOTS_PER_BLOCK;
		rem = need % SLOTS_PER_BLOCK;
		last = blocks_used() - (full + (rem != 0));
		if (last < 0) return -1;
		if (hi > last) hi = last;
		for (int b = lo; b <= hi; b++) begin
			ok = 1;
			for (int i = 0; i < full && ok; i++)
				if (!blk_empty(b + i)) ok = 0;
			if (!ok) continue;
			if (rem != 0 && !head_free(b + full, rem)) continue;
			return b * SLOTS_PER_BLOCK;
		end
		return -1;
	endfunction

	function automatic int fit_pair(int lo, int hi, int need);
		int suf;
		if (need < 2 || need > 2 * SLOTS_PER_BLOCK - 1) return -1;
		if (hi > blocks_used() - 2) hi = blocks_used() - 2;
		for (int b = lo; b <= hi; b++) begin
			if (blk_full(b) || blk_full(b + 1)) continue;
			suf = tail_free(b);
			if (suf == 0 || suf >= need) continue;
			if (head_free(b + 1, need - suf))
				return b * SLOTS_PER_BLOCK + (SLOTS_PER_BLOCK - suf);
		end
		return -1;
	endfunction

	function automatic int fit_unaligned(int lo, int hi, int need);
		int suf, st;
		if (hi > blocks_used() - 1) hi = blocks_used() - 1;
		for (int b = lo; b <= hi; b++) begin
			if (blk_full(b)) continue;
			suf = tail_free(b);
			if (suf == 0) continue;
			st = b * SLOTS_PER_BLOCK + (SLOTS_PER_BLOCK - suf);
			if (span_free(st, need)) return st;
		end
		return -1;
	endfunction

	function automatic int find_run(int need);
		int nb, st, at;
		nb = blocks_used();
		st = scan_from;
		if (st >= nb) st = 0;
		if (need <= SLOTS_PER_BLOCK) begin
			for (int b = st; b < nb; b++) begin
				at = fit_in_block(b, need);
				if (at >= 0) return at;
			end
			for (int b = 0; b < st; b++) begin
				at = fit_in_block(b, need);
				if (at >= 0) return at;
			end
			at = fit_pair(st, nb - 1, need);
			if (at >= 0) return at;
			return fit_pair(0, st - 1, need);
		end
		at = fit_aligned(st, nb - 1, need);
		if (at >= 0) return at;
		at = fit_aligned(0, st - 1, need);
		if (at >= 0) return at;
		at = fit_unaligned(st, nb - 1, need);
		if (at >= 0) return at;
		return fit_unaligned(0, st - 1, need);
	endfunction

	// applies one request to the predicted state and returns its result
	function automatic alloc_result_t apply_request(logic [1:0] act, int idx, int cnt);
		alloc_result_t r;
		int total, at, first, last, s, nxt;
		total = blocks_used() * SLOTS_PER_BLOCK;
		at = 0;
		r.st = ST_OK;
		if (cnt == 0) begin
			r.st = ST_ZERO;
		end else if (act == ACT_SEARCH || act == ACT_FIXED) begin
			if (act == ACT_FIXED) begin
				if (idx + cnt > total) r.st = ST_RANGE;
				else if (!span_free(idx, cnt)) r.st = ST_FAIL;
				else at = idx;
			end else begin
				at = find_run(cnt);
				if (at < 0) begin
					r.st = ST_FAIL;
					at = 0;
				end
			end
			if (r.st == ST_OK) begin
				first = at / SLOTS_PER_BLOCK;
				last = (at + cnt - 1) / SLOTS_PER_BLOCK;
				for (int b = first; b <= last; b++)
					if (!heap_mapped[b]) begin
						heap_mapped[b] = 1;
						heap_bits[b] = '0;
						mapped_total++;
					end
				for (int i = 0; i < cnt; i++) begin
					s = at + i;
					heap_bits[s / SLOTS_PER_BLOCK][s % SLOTS_PER_BLOCK] = 1'b1;
				end
				if (act == ACT_SEARCH) begin
					nxt = (at + cnt) / SLOTS_PER_BLOCK;
					if (nxt > scan_from) scan_from = nxt;
				end
			end
		end else if (act == ACT_FREE) begin
			if (idx + cnt > total) begin
				r.st = ST_RANGE;
			end else begin
				at = idx;
				first = idx / SLOTS_PER_BLOCK;
				last = (idx + cnt - 1) / SLOTS_PER_BLOCK;
				for (int i = 0; i < cnt; i++) begin
					s = idx + i;
					heap_bits[s / SLOTS_PER_BLOCK][s % SLOTS_PER_BLOCK] = 1'b0;
				end
				for (int b = first; b <= last; b++) begin
					if (heap_bits[b] != 0 || !heap_mapped[b] || cfg_keep) continue;
					heap_mapped[b] = 0;
					if (mapped_total > 0) mapped_total--;
				end
				if (scan_from > first) scan_from = first;
			end
		end else begin
			r.st = ST_FAIL;
		end
		r.first = (r.st == ST_OK) ? at[IDX_W-1:0] : '0;
		r.nmapped = mapped_total[NB_W-1:0];
		return r;
	endfunction

	task automatic send_request(logic [1:0] act, int idx, int cnt);
		alloc_result_t r;
		if (burst_left == 0) begin
			@(negedge clk);
			start = 0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		start = 1;
		action = act;
		slot_index = idx[IDX_W-1:0];
		slot_count = cnt[CNT_W-1:0];
		do @(posedge clk); while (busy);
		r = apply_request(act, idx & 16'h3FFF, cnt & 16'h7FFF);
		result_q.push_back(r);
		if (r.st == ST_OK && (act == ACT_SEARCH || act == ACT_FIXED)) begin
			live_runs.push_back('{first: r.first, cnt: cnt});
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 0;
		wait (result_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value[NB_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_AVAIL) cfg_avail = value & 9'h1FF;
		else if (idx == CFG_KEEP) cfg_keep = value & 1;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_regs(int avail, bit keep);
		wait_idle();
		write_reg(CFG_AVAIL, avail);
		write_reg(CFG_KEEP, keep);
	endtask

	task automatic free_everything();
		send_request(ACT_FREE, 0, blocks_used() * SLOTS_PER_BLOCK);
		live_runs.delete();
	endtask

	// result strobes are checked against the oldest prediction
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && done) begin
			if (result_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: st=%0d start=%0d mapped=%0d",
					status, slot_start, mapped_blocks);
			end else begin
				e = result_q.pop_front();
				if (status !== e.st || slot_start !== e.first || mapped_blocks !== e.nmapped) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st=%0d start=%0d mapped=%0d got st=%0d start=%0d mapped=%0d",
							e.st, e.first, e.nmapped, status, slot_start, mapped_blocks);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("slot_bitmap_range_allocator_test: FAIL");
			$finish;
		end
	end

	task automatic test_zero_count();
		send_request(ACT_SEARCH, 0, 0);
		send_request(ACT_FIXED, 16383, 0);
		send_request(ACT_FREE, 5, 0);
		send_request(ACT_UNDEF, 16383, 16384);
		send_request(ACT_UNDEF, 0, 1);
	endtask

	task automatic test_extremes();
		send_request(ACT_FIXED, 0, 1);
		send_request(ACT_FIXED, 16383, 1);
		send_request(ACT_FIXED, 16383, 2);
		send_request(ACT_SEARCH, 0, 64);
		send_request(ACT_SEARCH, 0, 127);
		send_request(ACT_SEARCH, 0, 200);
		send_request(ACT_FREE, 16383, 2);
		send_request(ACT_FREE, 100, 30);
		free_everything();
		send_request(ACT_SEARCH, 0, 16384);
		send_request(ACT_SEARCH, 0, 1);
		free_everything();
		send_request(ACT_FIXED, 0, 16384);
		send_request(ACT_FREE, 9000, 500);
		free_everything();
	endtask

	task automatic test_free_unused();
		set_regs(256, 1);
		send_request(ACT_FREE, 300, 40);
		send_request(ACT_SEARCH, 0, 10);
		send_request(ACT_FREE, 0, 10);
		free_everything();
	endtask

	task automatic test_block_limits();
		set_regs(0, 0);
		send_request(ACT_SEARCH, 0, 1);
		send_request(ACT_FIXED, 0, 1);
		send_request(ACT_FREE, 0, 1);
		set_regs(1, 0);
		send_request(ACT_SEARCH, 0, 65);
		send_request(ACT_SEARCH, 0, 64);
		send_request(ACT_FIXED, 63, 2);
		free_everything();
		set_regs(511, 0);
		send_request(ACT_FIXED, 16320, 64);
		free_everything();
	endtask

	task automatic random_item();
		int r, k, nb;
		run_t run;
		r = $urandom_range(0, 99);
		nb = blocks_used();
		if (r < 40) begin
			k = $urandom_range(0, 99);
			if (k < 90) send_request(ACT_SEARCH, $urandom, $urandom_range(1, 70));
			else if (k < 98) send_request(ACT_SEARCH, $urandom, $urandom_range(65, 400));
			else send_request(ACT_SEARCH, $urandom, $urandom_range(1, 16384));
		end else if (r < 60) begin
			send_request(ACT_FIXED, $urandom_range(0, nb * SLOTS_PER_BLOCK + 63) & 16'h3FFF,
				$urandom_range(1, 80));
		end else if (r < 92 && live_runs.size() > 0) begin
			k = $urandom_range(0, live_runs.size() - 1);
			run = live_runs[k];
			live_runs.delete(k);
			send_request(ACT_FREE, run.first, run.cnt);
		end else if (r < 99) begin
			send_request($urandom_range(0, 3), $urandom, $urandom);
		end else begin
			free_everything();
		end
	endtask

	task automatic test_random();
		int avail_pick [6] = '{256, 1, 2, 8, 511, 0};
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(ph == 5 ? $urandom_range(3, 256) : avail_pick[ph], $urandom_range(0, 1));
			for (int i = 0; i < RAND_ITEMS / 6; i++) random_item();
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		start = 0;
		action = ACT_SEARCH;
		slot_index = '0;
		slot_count = '0;
		cfg_valid = 0;
		cfg_index = CFG_AVAIL;
		cfg_data = '0;
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			heap_bits[b] = '0;
			heap_mapped[b] = 0;
		end
		scan_from = 0;
		mapped_total = 0;
		cfg_avail = 256;
		cfg_keep = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_zero_count();
		test_extremes();
		test_free_unused();
		test_block_limits();
		test_random();

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("slot_bitmap_range_allocator_test: PASS");
		end else begin
			$display("slot_bitmap_range_allocator_test: FAIL");
		end
		$finish;
	end

endmodule
